// ----- design/hs_pkg.sv -----
// hs_pkg: shared constants, word types and microcode types for the heap sorter.
// Depends on nothing; used by hs_seq, hs_dp and heap_sort.
package hs_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int WIDE_W    = ADDR_W + 2;
    localparam int PC_W      = 5;

    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        logic signed [31:0] value;
        logic               is_last;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_run;
        logic               dropped;
    } t_out_word;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_BUILD_INIT,
        OP_PDEC,
        OP_RD_ROOT,
        OP_HOLD_ROOT,
        OP_WR_ROOT,
        OP_WR_END,
        OP_K_CLR,
        OP_RD_K,
        OP_PUT,
        OP_CLR,
        OP_RD_NODE,
        OP_LATCH_NODE,
        OP_CMP_LC,
        OP_CMP_RC,
        OP_WR_NODE,
        OP_WR_TOP
    } t_dp_op;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_WAIT,
        BR_JUMP_IF,
        BR_GOTO,
        BR_CALL,
        BR_RET_IF
    } t_br;

    typedef enum logic [2:0] {
        C_NONE,
        C_IN_LAST,
        C_P_ZERO,
        C_SIZE_LE1,
        C_K_MORE,
        C_LC_GE_SIZE,
        C_TOP_IS_NODE,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_dp_op op;
        t_br    br;
        t_cond  cond;
        t_pc    target;
    } t_ctrl;

    typedef struct packed {
        logic in_last;
        logic p_zero;
        logic size_le1;
        logic k_more;
        logic lc_ge_size;
        logic top_is_node;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- design/hs_seq.sv -----
// hs_seq: microcode ROM, step counter, link register and branch logic.
// Depends on hs_pkg.
module hs_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hs_pkg::t_dp_stat i_stat,
    output hs_pkg::t_dp_op   o_op
);
    import hs_pkg::*;

    localparam t_pc S_LOAD      = t_pc'(0);
    localparam t_pc S_BINIT     = t_pc'(1);
    localparam t_pc S_BLOOP     = t_pc'(2);
    localparam t_pc S_BSTEP     = t_pc'(3);
    localparam t_pc S_BBACK     = t_pc'(4);
    localparam t_pc S_SCHECK    = t_pc'(5);
    localparam t_pc S_SRD       = t_pc'(6);
    localparam t_pc S_SHOLD     = t_pc'(7);
    localparam t_pc S_SWROOT    = t_pc'(8);
    localparam t_pc S_SWEND     = t_pc'(9);
    localparam t_pc S_SBACK     = t_pc'(10);
    localparam t_pc S_EINIT     = t_pc'(11);
    localparam t_pc S_ERD       = t_pc'(12);
    localparam t_pc S_EPUT      = t_pc'(13);
    localparam t_pc S_ELOOP     = t_pc'(14);
    localparam t_pc S_FIN       = t_pc'(15);
    localparam t_pc S_SIFT0     = t_pc'(16);
    localparam t_pc S_SIFT1     = t_pc'(17);
    localparam t_pc S_SIFT2     = t_pc'(18);
    localparam t_pc S_SIFT3     = t_pc'(19);
    localparam t_pc S_SIFT4     = t_pc'(20);
    localparam t_pc S_SIFT5     = t_pc'(21);

    function automatic t_ctrl rom(input t_pc pc);
        t_ctrl w;
        w = '{op: OP_NONE, br: BR_NEXT, cond: C_NONE, target: S_LOAD};
        case (pc)
            S_LOAD:   w = '{OP_LOAD,       BR_WAIT,    C_IN_LAST,     S_LOAD};
            S_BINIT:  w = '{OP_BUILD_INIT, BR_NEXT,    C_NONE,        S_LOAD};
            S_BLOOP:  w = '{OP_NONE,       BR_JUMP_IF, C_P_ZERO,      S_SCHECK};
            S_BSTEP:  w = '{OP_PDEC,       BR_CALL,    C_NONE,        S_SIFT0};
            S_BBACK:  w = '{OP_NONE,       BR_GOTO,    C_NONE,        S_BLOOP};
            S_SCHECK: w = '{OP_NONE,       BR_JUMP_IF, C_SIZE_LE1,    S_EINIT};
            S_SRD:    w = '{OP_RD_ROOT,    BR_NEXT,    C_NONE,        S_LOAD};
            S_SHOLD:  w = '{OP_HOLD_ROOT,  BR_NEXT,    C_NONE,        S_LOAD};
            S_SWROOT: w = '{OP_WR_ROOT,    BR_NEXT,    C_NONE,        S_LOAD};
            S_SWEND:  w = '{OP_WR_END,     BR_CALL,    C_NONE,        S_SIFT0};
            S_SBACK:  w = '{OP_NONE,       BR_GOTO,    C_NONE,        S_SCHECK};
            S_EINIT:  w = '{OP_K_CLR,      BR_NEXT,    C_NONE,        S_LOAD};
            S_ERD:    w = '{OP_RD_K,       BR_NEXT,    C_NONE,        S_LOAD};
            S_EPUT:   w = '{OP_PUT,        BR_WAIT,    C_OUT_FREE,    S_LOAD};
            S_ELOOP:  w = '{OP_NONE,       BR_JUMP_IF, C_K_MORE,      S_ERD};
            S_FIN:    w = '{OP_CLR,        BR_GOTO,    C_NONE,        S_LOAD};
            S_SIFT0:  w = '{OP_RD_NODE,    BR_RET_IF,  C_LC_GE_SIZE,  S_LOAD};
            S_SIFT1:  w = '{OP_LATCH_NODE, BR_NEXT,    C_NONE,        S_LOAD};
            S_SIFT2:  w = '{OP_CMP_LC,     BR_NEXT,    C_NONE,        S_LOAD};
            S_SIFT3:  w = '{OP_CMP_RC,     BR_NEXT,    C_NONE,        S_LOAD};
            S_SIFT4:  w = '{OP_WR_NODE,    BR_RET_IF,  C_TOP_IS_NODE, S_LOAD};
            S_SIFT5:  w = '{OP_WR_TOP,     BR_GOTO,    C_NONE,        S_SIFT0};
            default:  w = '{OP_NONE,       BR_GOTO,    C_NONE,        S_LOAD};
        endcase
        return w;
    endfunction

    t_pc   r_pc, n_pc;
    t_pc   r_link, n_link;
    t_ctrl ctrl;
    logic  cond_true;
    t_pc   pc_inc;

    assign ctrl   = rom(r_pc);
    assign o_op   = ctrl.op;
    assign pc_inc = r_pc + t_pc'(1);

    always_comb begin
        case (ctrl.cond)
            C_NONE:        cond_true = 1'b1;
            C_IN_LAST:     cond_true = i_stat.in_last;
            C_P_ZERO:      cond_true = i_stat.p_zero;
            C_SIZE_LE1:    cond_true = i_stat.size_le1;
            C_K_MORE:      cond_true = i_stat.k_more;
            C_LC_GE_SIZE:  cond_true = i_stat.lc_ge_size;
            C_TOP_IS_NODE: cond_true = i_stat.top_is_node;
            C_OUT_FREE:    cond_true = i_stat.out_free;
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb begin
        n_pc   = pc_inc;
        n_link = r_link;
        case (ctrl.br)
            BR_NEXT:    n_pc = pc_inc;
            BR_WAIT:    n_pc = cond_true ? pc_inc : r_pc;
            BR_JUMP_IF: n_pc = cond_true ? ctrl.target : pc_inc;
            BR_GOTO:    n_pc = ctrl.target;
            BR_CALL: begin
                n_pc   = ctrl.target;
                n_link = pc_inc;
            end
            BR_RET_IF:  n_pc = cond_true ? r_link : pc_inc;
            default:    n_pc = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= S_LOAD;
            r_link <= S_LOAD;
        end else begin
            r_pc   <= n_pc;
            r_link <= n_link;
        end
    end

endmodule

// ----- design/hs_dp.sv -----
// hs_dp: heap store, index and value registers, compare logic and output register.
// Depends on hs_pkg; driven one operation per cycle by hs_seq.
module hs_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hs_pkg::t_dp_op    i_op,
    input  logic              i_in_valid,
    input  hs_pkg::t_in_word  i_in,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output hs_pkg::t_out_word o_out,
    input  logic              i_out_stall,
    output hs_pkg::t_dp_stat  o_stat
);
    import hs_pkg::*;

    logic signed [31:0] r_mem [MAX_ITEMS];
    logic signed [31:0] r_rdata;

    logic [CNT_W-1:0]   r_cnt, r_p, r_size, r_k;
    logic               r_ovf;
    logic [ADDR_W-1:0]  r_node, r_top;
    logic signed [31:0] r_nodev, r_topv;
    logic               r_out_valid;
    t_out_word          r_out;

    logic               we, re;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic signed [31:0] wdata;
    logic               in_acc, room, out_free;
    logic [WIDE_W-1:0]  lc_ext, rc_ext, size_ext;
    logic [CNT_W-1:0]   size_m1, p_m1, k_inc;

    assign lc_ext   = {1'b0, r_node, 1'b1};
    assign rc_ext   = lc_ext + WIDE_W'(1);
    assign size_ext = WIDE_W'(r_size);
    assign size_m1  = r_size - CNT_W'(1);
    assign p_m1     = r_p - CNT_W'(1);
    assign k_inc    = r_k + CNT_W'(1);
    assign room     = r_cnt < CNT_W'(MAX_ITEMS);
    assign in_acc   = i_in_valid && (i_op == OP_LOAD);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (i_op != OP_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_stat.in_last     = in_acc && i_in.is_last;
    assign o_stat.p_zero      = (r_p == '0);
    assign o_stat.size_le1    = (r_size <= CNT_W'(1));
    assign o_stat.k_more      = (r_k != r_cnt);
    assign o_stat.lc_ge_size  = (lc_ext >= size_ext);
    assign o_stat.top_is_node = (r_top == r_node);
    assign o_stat.out_free    = out_free;

    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = '0;
        raddr = '0;
        wdata = r_nodev;
        case (i_op)
            OP_LOAD: begin
                we    = in_acc && room;
                waddr = r_cnt[ADDR_W-1:0];
                wdata = i_in.value;
            end
            OP_RD_ROOT: re = 1'b1;
            OP_HOLD_ROOT: begin
                re    = 1'b1;
                raddr = size_m1[ADDR_W-1:0];
            end
            OP_WR_ROOT: begin
                we    = 1'b1;
                wdata = r_rdata;
            end
            OP_WR_END: begin
                we    = 1'b1;
                waddr = size_m1[ADDR_W-1:0];
            end
            OP_RD_K: begin
                re    = 1'b1;
                raddr = r_k[ADDR_W-1:0];
            end
            OP_RD_NODE: begin
                re    = 1'b1;
                raddr = r_node;
            end
            OP_LATCH_NODE: begin
                re    = 1'b1;
                raddr = lc_ext[ADDR_W-1:0];
            end
            OP_CMP_LC: begin
                re    = 1'b1;
                raddr = rc_ext[ADDR_W-1:0];
            end
            OP_WR_NODE: begin
                we    = 1'b1;
                waddr = r_node;
                wdata = r_topv;
            end
            OP_WR_TOP: begin
                we    = 1'b1;
                waddr = r_top;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_BUILD_INIT: begin
                r_size <= r_cnt;
                r_p    <= r_cnt >> 1;
            end
            OP_PDEC: begin
                r_p    <= p_m1;
                r_node <= p_m1[ADDR_W-1:0];
            end
            OP_HOLD_ROOT: r_nodev <= r_rdata;
            OP_WR_END: begin
                r_size <= size_m1;
                r_node <= '0;
            end
            OP_K_CLR: r_k <= '0;
            OP_PUT: begin
                if (out_free) begin
                    r_out.sorted_value <= r_rdata;
                    r_out.end_of_run   <= (k_inc == r_cnt);
                    r_out.dropped      <= r_ovf;
                    r_k                <= k_inc;
                end
            end
            OP_LATCH_NODE: begin
                r_nodev <= r_rdata;
                r_topv  <= r_rdata;
                r_top   <= r_node;
            end
            OP_CMP_LC: begin
                if (r_rdata > r_topv) begin
                    r_top  <= lc_ext[ADDR_W-1:0];
                    r_topv <= r_rdata;
                end
            end
            OP_CMP_RC: begin
                if ((rc_ext < size_ext) && (r_rdata > r_topv)) begin
                    r_top  <= rc_ext[ADDR_W-1:0];
                    r_topv <= r_rdata;
                end
            end
            OP_WR_TOP: r_node <= r_top;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (room) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (i_op == OP_CLR) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
            if (i_op == OP_PUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- design/heap_sort.sv -----
// heap_sort: top level of the heapsort block; microcode sequencer plus datapath.
// Depends on hs_pkg, hs_seq and hs_dp.
//
//   channel | direction | handshake                      | word
//   in      | input     | i_in_valid / o_in_stall        | t_in_word  (value, is_last)
//   out     | output    | o_out_valid / i_out_stall      | t_out_word (sorted_value, ...)
//
// Loading accepts a word whenever one is valid; the word marked last starts the sort.
// Each sift-down level reads the node and both children, picks the largest and swaps it down;
// it stops at a leaf or when the node is already the largest. For n words the block heapifies
// from each parent, moves each element but one to the end, then emits every result in order.
// Reset clears the word count, overflow flag, output valid and the step counter.
// Input is stalled after the last word until the final result is loaded and the word count is cleared.
module heap_sort (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  hs_pkg::t_in_word  i_in,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output hs_pkg::t_out_word o_out,
    input  logic              i_out_stall
);
    import hs_pkg::*;

    t_dp_op   op;
    t_dp_stat stat;

    hs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_op    (op)
    );

    hs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .o_stat      (stat)
    );

endmodule
